// ===== sv/ccs_pkg.sv =====
// Shared types and constants of the congruence closure saturation block.
package ccs_pkg;

  localparam int MAX_STRINGS  = 1024;
  localparam int MAX_CONTEXTS = 1024;
  localparam int MAX_CONCATS  = 1024;
  localparam int SCRATCH      = (MAX_CONTEXTS > MAX_CONCATS) ? MAX_CONTEXTS : MAX_CONCATS;

  localparam int ID_W   = 10;                       // width of a string id
  localparam int CNT_W  = 11;                       // counts up to MAX_STRINGS
  localparam int CTX_AW = $clog2(MAX_CONTEXTS);
  localparam int CAT_AW = $clog2(MAX_CONCATS);
  localparam int KEY_AW = $clog2(SCRATCH);
  localparam int IDX_W  = $clog2(SCRATCH + 1);      // record counters and fill counts
  localparam int KEY_W  = 2 * ID_W;
  localparam int PID_W  = $clog2(MAX_STRINGS);      // parent memory address

  typedef enum logic [1:0] {
    M_CTX = 2'd0,
    M_CAT = 2'd1,
    M_SAT = 2'd2,
    M_QRY = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_BADID = 2'd1,
    ST_FULL  = 2'd2,
    ST_LATE  = 2'd3
  } status_t;

  typedef struct packed {
    mode_t             mode;
    logic [ID_W-1:0]   a_id;
    logic [ID_W-1:0]   b_id;
    logic [ID_W-1:0]   c_id;
  } in_t;

  typedef struct packed {
    status_t           status;
    logic              is_equivalent;
    logic [CNT_W-1:0]  classes_now;
    logic [CNT_W-1:0]  rounds_taken;
  } out_t;

  typedef struct packed {
    logic [ID_W-1:0]   left;
    logic [ID_W-1:0]   right;
    logic [ID_W-1:0]   value;
  } triple_t;

  typedef struct packed {
    logic              valid;
    in_t               cmd;
  } eng_req_t;

  typedef struct packed {
    logic              ready;
    logic              valid;
    out_t              res;
  } eng_rsp_t;

endpackage

// ===== sv/ccs_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module ccs_ram #(
  parameter int DW = 8,
  parameter int AW = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/ccs_engine.sv =====
// Sequencer over the parent, record and key memories: loads, queries and saturation.
module ccs_engine import ccs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_data,
  input  eng_req_t         req,
  output eng_rsp_t         rsp
);

  typedef enum logic [19:0] {
    S_CLEAR  = 20'h00001,
    S_IDLE   = 20'h00002,
    S_FIND   = 20'h00004,
    S_QB     = 20'h00008,
    S_QRES   = 20'h00010,
    S_RSTART = 20'h00020,
    S_PSTART = 20'h00040,
    S_KRD    = 20'h00080,
    S_KL     = 20'h00100,
    S_KR     = 20'h00200,
    S_KWR    = 20'h00400,
    S_PAIRI  = 20'h00800,
    S_PAIRL  = 20'h01000,
    S_JRD    = 20'h02000,
    S_JCMP   = 20'h04000,
    S_JVAL   = 20'h08000,
    S_UVI    = 20'h10000,
    S_UNITE  = 20'h20000,
    S_INEXT  = 20'h40000,
    S_PEND   = 20'h80000
  } state_t;

  state_t            state_r, state_nxt, ret_r, ret_nxt;
  logic [CNT_W-1:0]  active_r, active_nxt, class_r, class_nxt, round_r, round_nxt;
  logic              done_r, done_nxt, ph_r, ph_nxt, uni_r, uni_nxt;
  logic [IDX_W-1:0]  ctx_fill_r, ctx_fill_nxt, cat_fill_r, cat_fill_nxt;
  logic [IDX_W-1:0]  i_r, i_nxt, j_r, j_nxt;
  logic [PID_W-1:0]  clr_r, clr_nxt;
  logic [ID_W-1:0]   fx_r, fx_nxt, ra_r, ra_nxt, rb_r, rb_nxt, vi_r, vi_nxt;
  logic [KEY_W-1:0]  ki_r, ki_nxt;

  // Memory ports
  logic              p_we;
  logic [PID_W-1:0]  p_waddr, p_raddr;
  logic [ID_W-1:0]   p_wdata, p_rdata;
  logic              ctx_we, cat_we;
  triple_t           t_wdata, ctx_rdata, cat_rdata, t_rdata;
  logic [IDX_W-1:0]  t_widx, t_ridx;
  logic              k_we;
  logic [KEY_W-1:0]  k_wdata, k_rdata;
  logic [IDX_W-1:0]  k_ridx;

  // Find launch
  logic              f_go;
  logic [ID_W-1:0]   f_val;
  state_t            f_ret;

  logic [IDX_W-1:0]  fill;
  logic [CNT_W-1:0]  cfg_clamped;
  logic              bad_ab, bad_c;

  ccs_ram #(.DW(ID_W), .AW(PID_W)) u_parent (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .raddr(p_raddr), .rdata(p_rdata)
  );

  ccs_ram #(.DW($bits(triple_t)), .AW(CTX_AW)) u_ctx (
    .clk(clk), .we(ctx_we), .waddr(t_widx[CTX_AW-1:0]), .wdata(t_wdata),
    .raddr(t_ridx[CTX_AW-1:0]), .rdata(ctx_rdata)
  );

  ccs_ram #(.DW($bits(triple_t)), .AW(CAT_AW)) u_cat (
    .clk(clk), .we(cat_we), .waddr(t_widx[CAT_AW-1:0]), .wdata(t_wdata),
    .raddr(t_ridx[CAT_AW-1:0]), .rdata(cat_rdata)
  );

  ccs_ram #(.DW(KEY_W), .AW(KEY_AW)) u_key (
    .clk(clk), .we(k_we), .waddr(i_r[KEY_AW-1:0]), .wdata(k_wdata),
    .raddr(k_ridx[KEY_AW-1:0]), .rdata(k_rdata)
  );

  assign t_rdata = ph_r ? cat_rdata : ctx_rdata;
  assign fill    = ph_r ? cat_fill_r : ctx_fill_r;
  assign bad_ab  = ({1'b0, req.cmd.a_id} >= active_r) || ({1'b0, req.cmd.b_id} >= active_r);
  assign bad_c   = {1'b0, req.cmd.c_id} >= active_r;
  assign cfg_clamped = (cfg_data > CNT_W'(MAX_STRINGS)) ? CNT_W'(MAX_STRINGS) : cfg_data;

  // Next state, memory controls and results
  always_comb begin
    state_nxt    = state_r;
    ret_nxt      = ret_r;
    active_nxt   = active_r;
    class_nxt    = class_r;
    round_nxt    = round_r;
    done_nxt     = done_r;
    ph_nxt       = ph_r;
    uni_nxt      = uni_r;
    ctx_fill_nxt = ctx_fill_r;
    cat_fill_nxt = cat_fill_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    clr_nxt      = clr_r;
    fx_nxt       = fx_r;
    ra_nxt       = ra_r;
    rb_nxt       = rb_r;
    vi_nxt       = vi_r;
    ki_nxt       = ki_r;
    p_we         = 1'b0;
    p_waddr      = clr_r;
    p_wdata      = ID_W'(clr_r);
    ctx_we       = 1'b0;
    cat_we       = 1'b0;
    t_wdata      = '{left: req.cmd.a_id, right: req.cmd.b_id, value: req.cmd.c_id};
    t_widx       = (req.cmd.mode == M_CTX) ? ctx_fill_r : cat_fill_r;
    t_ridx       = i_r;
    k_we         = 1'b0;
    k_wdata      = {ra_r, rb_r};
    k_ridx       = i_r;
    f_go         = 1'b0;
    f_val        = fx_r;
    f_ret        = S_IDLE;
    rsp.ready    = (state_r == S_IDLE);
    rsp.valid    = 1'b0;
    rsp.res      = '{status: ST_OK, is_equivalent: 1'b0,
                     classes_now: class_r, rounds_taken: round_r};

    unique case (state_r)
      // Sweep the parent memory so that every id is its own root
      S_CLEAR: begin
        p_we    = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == {PID_W{1'b1}}) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req.valid) begin
          unique case (req.cmd.mode) inside
            M_CTX, M_CAT: begin
              rsp.valid = 1'b1;
              if (done_r) begin
                rsp.res.status = ST_LATE;
              end else if (bad_ab || bad_c) begin
                rsp.res.status = ST_BADID;
              end else if (req.cmd.mode == M_CTX) begin
                if (ctx_fill_r >= IDX_W'(MAX_CONTEXTS)) begin
                  rsp.res.status = ST_FULL;
                end else begin
                  ctx_we       = 1'b1;
                  ctx_fill_nxt = ctx_fill_r + 1'b1;
                end
              end else begin
                if (cat_fill_r >= IDX_W'(MAX_CONCATS)) begin
                  rsp.res.status = ST_FULL;
                end else begin
                  cat_we       = 1'b1;
                  cat_fill_nxt = cat_fill_r + 1'b1;
                end
              end
            end
            M_SAT: begin
              if (done_r) begin
                rsp.valid = 1'b1;
              end else begin
                round_nxt = '0;
                state_nxt = S_RSTART;
              end
            end
            default: begin
              if (bad_ab) begin
                rsp.valid      = 1'b1;
                rsp.res.status = ST_BADID;
              end else begin
                vi_nxt = req.cmd.b_id;
                f_go   = 1'b1;
                f_val  = req.cmd.a_id;
                f_ret  = S_QB;
              end
            end
          endcase
        end
      end
      // Walk parent links until an entry points to itself; push the root
      S_FIND: begin
        if (p_rdata == fx_r) begin
          ra_nxt    = rb_r;
          rb_nxt    = fx_r;
          state_nxt = ret_r;
        end else begin
          fx_nxt = p_rdata;
        end
      end
      S_QB: begin
        f_go  = 1'b1;
        f_val = vi_r;
        f_ret = S_QRES;
      end
      S_QRES: begin
        rsp.valid             = 1'b1;
        rsp.res.is_equivalent = (ra_r == rb_r);
        state_nxt             = S_IDLE;
      end
      S_RSTART: begin
        round_nxt = round_r + 1'b1;
        uni_nxt   = 1'b0;
        ph_nxt    = 1'b0;
        state_nxt = S_PSTART;
      end
      S_PSTART: begin
        i_nxt     = '0;
        state_nxt = (fill == '0) ? S_PEND : S_KRD;
      end
      // Key pass: snapshot the root pair of every record
      S_KRD: begin
        state_nxt = S_KL;
      end
      S_KL: begin
        vi_nxt = t_rdata.right;
        f_go   = 1'b1;
        f_val  = t_rdata.left;
        f_ret  = S_KR;
      end
      S_KR: begin
        f_go  = 1'b1;
        f_val = vi_r;
        f_ret = S_KWR;
      end
      S_KWR: begin
        k_we = 1'b1;
        if ((i_r + 1'b1) == fill) begin
          i_nxt     = IDX_W'(1);
          state_nxt = (fill < IDX_W'(2)) ? S_PEND : S_PAIRI;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_KRD;
        end
      end
      // Pair pass: join each record's value to the first earlier record with its key
      S_PAIRI: begin
        state_nxt = S_PAIRL;
      end
      S_PAIRL: begin
        ki_nxt    = k_rdata;
        vi_nxt    = t_rdata.value;
        j_nxt     = '0;
        state_nxt = S_JRD;
      end
      S_JRD: begin
        k_ridx    = j_r;
        state_nxt = S_JCMP;
      end
      S_JCMP: begin
        if (k_rdata == ki_r) begin
          t_ridx    = j_r;
          state_nxt = S_JVAL;
        end else if ((j_r + 1'b1) == i_r) begin
          state_nxt = S_INEXT;
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = S_JRD;
        end
      end
      S_JVAL: begin
        f_go  = 1'b1;
        f_val = t_rdata.value;
        f_ret = S_UVI;
      end
      S_UVI: begin
        f_go  = 1'b1;
        f_val = vi_r;
        f_ret = S_UNITE;
      end
      // Link the larger root under the smaller one
      S_UNITE: begin
        if (ra_r != rb_r) begin
          p_we    = 1'b1;
          p_waddr = PID_W'((ra_r < rb_r) ? rb_r : ra_r);
          p_wdata = (ra_r < rb_r) ? ra_r : rb_r;
          uni_nxt = 1'b1;
          if (class_r != '0) begin
            class_nxt = class_r - 1'b1;
          end
        end
        state_nxt = S_INEXT;
      end
      S_INEXT: begin
        if ((i_r + 1'b1) == fill) begin
          state_nxt = S_PEND;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_PAIRI;
        end
      end
      S_PEND: begin
        if (!ph_r) begin
          ph_nxt    = 1'b1;
          state_nxt = S_PSTART;
        end else if (uni_r) begin
          state_nxt = S_RSTART;
        end else begin
          done_nxt  = 1'b1;
          rsp.valid = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase

    if (f_go) begin
      fx_nxt    = f_val;
      ret_nxt   = f_ret;
      state_nxt = S_FIND;
    end

    // A register write starts afresh
    if (cfg_we) begin
      active_nxt   = cfg_clamped;
      class_nxt    = cfg_clamped;
      round_nxt    = '0;
      done_nxt     = 1'b0;
      ctx_fill_nxt = '0;
      cat_fill_nxt = '0;
      clr_nxt      = '0;
      state_nxt    = S_CLEAR;
    end
  end

  assign p_raddr   = (state_r == S_FIND) ? PID_W'(p_rdata) : PID_W'(f_val);

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      ret_r      <= S_IDLE;
      active_r   <= CNT_W'(MAX_STRINGS);
      class_r    <= CNT_W'(MAX_STRINGS);
      round_r    <= '0;
      done_r     <= 1'b0;
      ph_r       <= 1'b0;
      uni_r      <= 1'b0;
      ctx_fill_r <= '0;
      cat_fill_r <= '0;
      i_r        <= '0;
      j_r        <= '0;
      clr_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      ret_r      <= ret_nxt;
      active_r   <= active_nxt;
      class_r    <= class_nxt;
      round_r    <= round_nxt;
      done_r     <= done_nxt;
      ph_r       <= ph_nxt;
      uni_r      <= uni_nxt;
      ctx_fill_r <= ctx_fill_nxt;
      cat_fill_r <= cat_fill_nxt;
      i_r        <= i_nxt;
      j_r        <= j_nxt;
      clr_r      <= clr_nxt;
    end
  end

  // Working values
  always_ff @(posedge clk) begin
    fx_r <= fx_nxt;
    ra_r <= ra_nxt;
    rb_r <= rb_nxt;
    vi_r <= vi_nxt;
    ki_r <= ki_nxt;
  end

endmodule

// ===== sv/congruence_closure_saturation.sv =====
// Top level: input handshake, result register and the closure engine.
//
// Loads and rejected items are answered from the idle state. A query walks the
// parent links from each of its two ids through the parent memory, then
// compares the two roots. A saturate runs rounds of two phases; in each phase
// every record takes two find walks to snapshot its key, then earlier records
// are scanned for a matching key in the key memory. After reset and after each
// register write a clearing pass rewrites every entry of the parent memory,
// during which no item is taken; no item is taken in the cycle of a register
// write either. The parent memory, walked one link a cycle, sets the pace of
// every find.
module congruence_closure_saturation import ccs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_t              in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_t             out_data,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_data
);

  eng_req_t req;
  eng_rsp_t rsp;
  logic     out_valid_r;
  out_t     out_data_r;

  // Take a transfer only when the engine is idle, no register write is under
  // way and the result slot is free
  assign in_stall  = cfg_we || !(rsp.ready && (!out_valid_r || !out_stall));
  assign req.valid = in_valid && !in_stall;
  assign req.cmd   = in_data;

  ccs_engine u_engine (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .req(req), .rsp(rsp)
  );

  // Hold the result until it is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rsp.valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp.valid) begin
      out_data_r <= rsp.res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== sv/ccs_checker.sv =====
// Port checker for the closure block and its bind.
module ccs_checker import ccs_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_stall,
  input in_t              in_data,
  input logic             out_valid,
  input logic             out_stall,
  input out_t             out_data,
  input logic             cfg_we
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Stalled input item holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("stalled input item changed");

  // No transfer in while a result waits stalled
  a_in_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while result stalled");

  // Register write starts the clearing pass
  a_cfg_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> in_stall)
    else $error("input open right after register write");

  // Equivalence only on an accepted query
  a_eq_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_equivalent |-> out_data.status == ST_OK)
    else $error("equivalence flagged on a rejected item");

endmodule

bind congruence_closure_saturation ccs_checker u_ccs_checker (.*);

// ===== tb/sv/tb_congruence_closure_saturation.sv =====
// Self-checking testbench for the congruence closure saturation block.
module tb_congruence_closure_saturation;
  import ccs_pkg::*;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  in_t              in_data;
  logic             out_valid;
  logic             out_stall;
  out_t             out_data;
  logic             cfg_we;
  logic [CNT_W-1:0] cfg_data;

  congruence_closure_saturation dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  // Mirror of the block: classes, tables and counters
  int      link_of [MAX_STRINGS];
  triple_t ctx_rec [MAX_CONTEXTS];
  triple_t cat_rec [MAX_CONCATS];
  int      ctx_fill;
  int      cat_fill;
  int      id_limit;
  int      class_tally;
  int      round_count;
  bit      saturated;

  out_t    pending_results[$];
  int      error_count;

  // Sender burst state
  int      burst_left;
  bit      no_gaps;

  // Receiver hold-off requests, counted by the stall process
  int      hold_asked;
  int      hold_seen;
  int      hold_left;
  int      style_left;
  int      stall_style;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic report(string what);
    error_count++;
    if (error_count < 60) $display("mismatch at %0t: %s", $time, what);
  endtask

  // Class tracking with path halving
  function automatic int root_of(int x);
    while (link_of[x] != x) begin
      link_of[x] = link_of[link_of[x]];
      x = link_of[x];
    end
    return x;
  endfunction

  function automatic int merge_classes(int a, int b);
    int ra;
    int rb;
    ra = root_of(a);
    rb = root_of(b);
    if (ra == rb) return 0;
    if (ra < rb) link_of[rb] = ra;
    else link_of[ra] = rb;
    if (class_tally > 0) class_tally--;
    return 1;
  endfunction

  function automatic void clear_classes();
    for (int i = 0; i < MAX_STRINGS; i++) link_of[i] = i;
    ctx_fill    = 0;
    cat_fill    = 0;
    class_tally = id_limit;
    round_count = 0;
    saturated   = 1'b0;
  endfunction

  // One phase: keys from roots at phase start, then unite values per key
  function automatic int congruence_pass(bit use_cat);
    int      keys [SCRATCH];
    int      n;
    int      joined;
    triple_t t;
    triple_t s;
    joined = 0;
    n = use_cat ? cat_fill : ctx_fill;
    for (int i = 0; i < n; i++) begin
      t = use_cat ? cat_rec[i] : ctx_rec[i];
      keys[i] = root_of(int'(t.left)) * MAX_STRINGS + root_of(int'(t.right));
    end
    for (int i = 1; i < n; i++) begin
      t = use_cat ? cat_rec[i] : ctx_rec[i];
      for (int j = 0; j < i; j++) begin
        if (keys[j] == keys[i]) begin
          s = use_cat ? cat_rec[j] : ctx_rec[j];
          joined += merge_classes(int'(s.value), int'(t.value));
          break;
        end
      end
    end
    return joined;
  endfunction

  function automatic out_t closure_result(in_t it);
    out_t r;
    int   joined;
    r = '0;
    r.status = ST_OK;
    case (it.mode)
      M_CTX, M_CAT: begin
        if (saturated) begin
          r.status = ST_LATE;
        end else if (int'(it.a_id) >= id_limit || int'(it.b_id) >= id_limit ||
                     int'(it.c_id) >= id_limit) begin
          r.status = ST_BADID;
        end else if (it.mode == M_CTX) begin
          if (ctx_fill >= MAX_CONTEXTS) r.status = ST_FULL;
          else begin
            ctx_rec[ctx_fill] = {it.a_id, it.b_id, it.c_id};
            ctx_fill++;
          end
        end else begin
          if (cat_fill >= MAX_CONCATS) r.status = ST_FULL;
          else begin
            cat_rec[cat_fill] = {it.a_id, it.b_id, it.c_id};
            cat_fill++;
          end
        end
      end
      M_SAT: begin
        if (!saturated) begin
          round_count = 0;
          do begin
            round_count++;
            joined = congruence_pass(1'b0);
            joined += congruence_pass(1'b1);
          end while (joined != 0);
          saturated = 1'b1;
        end
      end
      default: begin
        if (int'(it.a_id) >= id_limit || int'(it.b_id) >= id_limit) r.status = ST_BADID;
        else r.is_equivalent = (root_of(int'(it.a_id)) == root_of(int'(it.b_id)));
      end
    endcase
    r.classes_now  = class_tally[CNT_W-1:0];
    r.rounds_taken = round_count[CNT_W-1:0];
    return r;
  endfunction

  // Offer one item, hold it until transfer, then maybe pause
  task automatic send_item(in_t it);
    int gap;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    pending_results.insert(pending_results.size(), closure_result(it));
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 40);
      gap = no_gaps ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_fields(mode_t m, int a, int b, int c);
    in_t it;
    it.mode = m;
    it.a_id = a[ID_W-1:0];
    it.b_id = b[ID_W-1:0];
    it.c_id = c[ID_W-1:0];
    send_item(it);
  endtask

  // Drain all results, then let the engine settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_id_limit(int v);
    int masked;
    wait_idle();
    cfg_we   <= 1'b1;
    cfg_data <= v[CNT_W-1:0];
    @(posedge clk);
    cfg_we   <= 1'b0;
    masked   = int'(v[CNT_W-1:0]);
    id_limit = (masked > MAX_STRINGS) ? MAX_STRINGS : masked;
    clear_classes();
  endtask

  // Check each result transfer against the oldest expectation
  always @(posedge clk) begin : result_check
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report("result with nothing outstanding");
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status)
          report($sformatf("status %0d, want %0d", out_data.status, want.status));
        if (out_data.is_equivalent !== want.is_equivalent)
          report($sformatf("is_equivalent %0b, want %0b",
                           out_data.is_equivalent, want.is_equivalent));
        if (out_data.classes_now !== want.classes_now)
          report($sformatf("classes_now %0d, want %0d",
                           out_data.classes_now, want.classes_now));
        if (out_data.rounds_taken !== want.rounds_taken)
          report($sformatf("rounds_taken %0d, want %0d",
                           out_data.rounds_taken, want.rounds_taken));
      end
    end
  end

  // Receiver stall pattern, with long hold-offs on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_seen != hold_asked) begin
      hold_seen <= hold_asked;
      hold_left <= 300;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      if (style_left == 0) begin
        stall_style <= $urandom_range(0, 2);
        style_left  <= $urandom_range(20, 120);
      end else begin
        style_left <= style_left - 1;
      end
      case (stall_style)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 1) == 0);
      endcase
    end
  end

  // Congruence over two rounds, extremes, early query, late loads
  task automatic test_directed();
    send_fields(M_QRY, 0, 0, 1023);
    send_fields(M_QRY, 0, 1023, 0);
    send_fields(M_CTX, 1023, 0, 1023);
    send_fields(M_CTX, 1, 2, 10);
    send_fields(M_CTX, 1, 2, 11);
    send_fields(M_CAT, 10, 3, 20);
    send_fields(M_CAT, 11, 3, 21);
    send_fields(M_CTX, 20, 4, 30);
    send_fields(M_CTX, 21, 4, 31);
    send_fields(M_CAT, 0, 0, 0);
    send_fields(M_QRY, 10, 11, 0);
    send_fields(M_SAT, 1023, 1023, 1023);
    send_fields(M_QRY, 10, 11, 0);
    send_fields(M_QRY, 30, 31, 0);
    send_fields(M_QRY, 20, 30, 0);
    send_fields(M_CTX, 5, 6, 7);
    send_fields(M_CAT, 1023, 1023, 1023);
    send_fields(M_SAT, 0, 0, 0);
    send_fields(M_QRY, 1023, 0, 0);
  endtask

  // Invalid ids under a small id range, and the empty range
  task automatic test_bad_ids();
    write_id_limit(16);
    send_fields(M_CTX, 16, 0, 0);
    send_fields(M_CAT, 0, 1023, 0);
    send_fields(M_CTX, 0, 0, 16);
    send_fields(M_QRY, 15, 16, 0);
    send_fields(M_QRY, 15, 15, 0);
    send_fields(M_SAT, 0, 0, 0);
    send_fields(M_CTX, 16, 16, 16);
    write_id_limit(0);
    send_fields(M_QRY, 0, 0, 0);
    send_fields(M_CTX, 0, 0, 0);
    send_fields(M_SAT, 0, 0, 0);
  endtask

  // Load, query, saturate, query and send noise items over a small id pool
  task automatic run_episode(int limit_value, bit with_hold);
    int    pool [12];
    int    top;
    int    loads;
    in_t   it;
    write_id_limit(limit_value);
    top = (id_limit > 0) ? id_limit - 1 : 0;
    for (int k = 0; k < 12; k++) pool[k] = $urandom_range(0, top);
    loads = $urandom_range(6, 36);
    if (with_hold) begin
      hold_asked++;
      no_gaps = 1'b1;
    end
    for (int k = 0; k < loads; k++) begin
      it.mode = ($urandom_range(0, 1) == 0) ? M_CTX : M_CAT;
      it.a_id = ID_W'(pool[$urandom_range(0, 5)]);
      it.b_id = ID_W'(pool[$urandom_range(0, 5)]);
      it.c_id = ID_W'(pool[$urandom_range(0, 11)]);
      if ($urandom_range(0, 9) == 0) it.a_id = ID_W'($urandom);
      if ($urandom_range(0, 9) == 0) it.c_id = ID_W'($urandom);
      send_item(it);
    end
    no_gaps = 1'b0;
    for (int k = 0; k < 3; k++)
      send_fields(M_QRY, pool[$urandom_range(0, 11)], pool[$urandom_range(0, 11)], $urandom);
    send_fields(M_SAT, $urandom, $urandom, $urandom);
    for (int k = 0; k < 12; k++) begin
      it.mode = M_QRY;
      it.a_id = ID_W'(pool[$urandom_range(0, 11)]);
      it.b_id = ID_W'(pool[$urandom_range(0, 11)]);
      it.c_id = ID_W'($urandom);
      if ($urandom_range(0, 9) == 0) it.b_id = ID_W'($urandom);
      send_item(it);
    end
    // Noise: any mode, any field values
    for (int k = 0; k < 4; k++) begin
      it = in_t'($urandom);
      send_item(it);
    end
  endtask

  task automatic test_random();
    int limits [6] = '{1024, 2047, 2, 1, 1024, 16};
    for (int e = 0; e < 18; e++) begin
      if (e < 6) run_episode(limits[e], e == 4);
      else run_episode($urandom_range(0, 3) == 0 ? $urandom_range(3, 2047)
                                                 : $urandom_range(3, 1023), 1'b0);
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_we      = 1'b0;
    cfg_data    = '0;
    error_count = 0;
    burst_left  = 1;
    no_gaps     = 1'b0;
    hold_asked  = 0;
    hold_seen   = 0;
    hold_left   = 0;
    style_left  = 0;
    stall_style = 0;
    id_limit    = MAX_STRINGS;
    clear_classes();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_bad_ids();
    test_random();
    wait_idle();
    repeat (50) @(posedge clk);
    if (error_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Hard stop on a hang
  initial begin
    #10000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
